// ===== hdl/twm_pkg.sv =====
// shared types, codes and helper functions for the two-wire adc interface master
// no dependencies; imported by every module of the block

package twm_pkg;

    // register map (index = paddr[3:2])
    localparam int RegAddrW  = 4;
    localparam int ApbDataW  = 32;
    localparam logic [1:0] REG_WAIT_TICKS     = 2'd0;
    localparam logic [1:0] REG_HALF_PERIOD    = 2'd1;
    localparam logic [1:0] REG_POWER_DOWN     = 2'd2;
    localparam logic [1:0] REG_POWER_UP       = 2'd3;

    localparam logic [19:0] WaitTicksReset  = 20'd78000;
    localparam logic [7:0]  HalfPeriodReset = 8'd1;
    localparam logic [19:0] PowerDownReset  = 20'd100;
    localparam logic [19:0] PowerUpReset    = 20'd100;

    // request codes
    localparam logic [2:0] OP_READ_SAMPLE = 3'd0;
    localparam logic [2:0] OP_READ_CFG    = 3'd1;
    localparam logic [2:0] OP_WRITE_CFG   = 3'd2;
    localparam logic [2:0] OP_POWER_DOWN  = 3'd3;
    localparam logic [2:0] OP_POWER_UP    = 3'd4;

    localparam logic [6:0] CMD_READ_CFG  = 7'h56;
    localparam logic [6:0] CMD_WRITE_CFG = 7'h65;

    localparam logic [5:0] SampleBits   = 6'd24;
    localparam logic [5:0] SampleFrame  = 6'd27;
    localparam logic [5:0] ConfigFrame  = 6'd46;

    localparam int InDataW  = 16;
    localparam int OutDataW = 40;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_HIGH,
        PH_LOW,
        PH_HOLD
    } phase_t;

    typedef struct packed {
        logic [19:0] wait_ticks;
        logic [7:0]  half_period_ticks;
        logic [19:0] power_down_ticks;
        logic [19:0] power_up_ticks;
    } cfg_t;

    typedef struct packed {
        logic        clk_level;
        logic        dio_drive;
        logic        dio_enable;
        logic        busy;
        logic        done;
        logic        status;
        logic [23:0] sample;
        logic [7:0]  config_byte;
    } result_t;

    // dio pin control for one clock of a frame
    function automatic logic [1:0] clock_pins(input logic [2:0] op, input logic [5:0] idx,
                                              input logic [7:0] wbyte);
        logic [6:0] cmd;
        logic [1:0] en_drv;
        begin
            cmd    = (op == OP_READ_CFG) ? CMD_READ_CFG : CMD_WRITE_CFG;
            en_drv = 2'b00;
            if (op == OP_READ_SAMPLE) begin
                if (idx == SampleBits + 6'd2) en_drv = 2'b11;
            end else if (idx inside {[6'd26:6'd28]}) begin
                en_drv = 2'b11;
            end else if (idx inside {[6'd29:6'd35]}) begin
                en_drv = {1'b1, cmd[3'(6'd35 - idx)]};
            end else if (op == OP_WRITE_CFG && (idx inside {[6'd37:6'd44]})) begin
                en_drv = {1'b1, wbyte[3'(6'd44 - idx)]};
            end else if (op == OP_WRITE_CFG && idx == 6'd45) begin
                en_drv = 2'b11;
            end
            return en_drv;
        end
    endfunction

    function automatic logic reads_bit(input logic [2:0] op, input logic [5:0] idx);
        begin
            if (op == OP_READ_SAMPLE) return idx < SampleBits;
            if (op == OP_READ_CFG) return idx inside {[6'd37:6'd44]};
            return 1'b0;
        end
    endfunction

endpackage

// ===== hdl/twm_cfg_regs.sv =====
// apb configuration registers of the two-wire adc interface master
// depends on twm_pkg

module twm_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twm_pkg::RegAddrW-1:0] paddr,
    input  logic [twm_pkg::ApbDataW-1:0] pwdata,
    output logic [twm_pkg::ApbDataW-1:0] prdata,
    output logic                         pready,
    output twm_pkg::cfg_t                cfg
);
    import twm_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wait_ticks        <= WaitTicksReset;
            cfg_reg.half_period_ticks <= HalfPeriodReset;
            cfg_reg.power_down_ticks  <= PowerDownReset;
            cfg_reg.power_up_ticks    <= PowerUpReset;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WAIT_TICKS:  cfg_reg.wait_ticks        <= pwdata[19:0];
                REG_HALF_PERIOD: cfg_reg.half_period_ticks <= pwdata[7:0];
                REG_POWER_DOWN:  cfg_reg.power_down_ticks  <= pwdata[19:0];
                REG_POWER_UP:    cfg_reg.power_up_ticks    <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WAIT_TICKS:  prdata = {12'd0, cfg_reg.wait_ticks};
            REG_HALF_PERIOD: prdata = {24'd0, cfg_reg.half_period_ticks};
            REG_POWER_DOWN:  prdata = {12'd0, cfg_reg.power_down_ticks};
            REG_POWER_UP:    prdata = {12'd0, cfg_reg.power_up_ticks};
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== hdl/twm_sequencer.sv =====
// per-tick sequencer: request decode, dio wait, frame clocking and power holds
// depends on twm_pkg

module twm_sequencer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic              kind,
    input  logic [2:0]        op,
    input  logic [7:0]        write_byte,
    input  logic              dio_level,
    input  twm_pkg::cfg_t     cfg,
    output twm_pkg::result_t res
);
    import twm_pkg::*;

    phase_t      phase_reg,    phase_next;
    logic [7:0]  half_cnt_reg, half_cnt_next;
    logic [5:0]  clk_idx_reg,  clk_idx_next;
    logic [23:0] shift_reg,    shift_next;
    logic [19:0] wait_cnt_reg, wait_cnt_next;
    logic        pdown_reg,    pdown_next;
    logic [2:0]  pend_op_reg,  pend_op_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        clk_st_reg,   clk_st_next;
    logic [23:0] sample_reg,   sample_next;
    logic [7:0]  cfgbyte_reg,  cfgbyte_next;
    logic        status_reg,   status_next;

    logic [7:0]  hp;
    logic [7:0]  half_inc;
    logic [5:0]  idx_inc;
    logic [5:0]  frame_len;
    logic [19:0] hold_limit;
    logic [1:0]  en_drv;
    logic        clk_o, busy_o, done_o;

    always_comb begin
        phase_next    = phase_reg;
        half_cnt_next = half_cnt_reg;
        clk_idx_next  = clk_idx_reg;
        shift_next    = shift_reg;
        wait_cnt_next = wait_cnt_reg;
        pdown_next    = pdown_reg;
        pend_op_next  = pend_op_reg;
        out_byte_next = out_byte_reg;
        clk_st_next   = clk_st_reg;
        sample_next   = sample_reg;
        cfgbyte_next  = cfgbyte_reg;
        status_next   = status_reg;
        hp            = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
        en_drv        = 2'b00;
        busy_o        = 1'b0;
        done_o        = 1'b0;

        // request pickup
        if (phase_reg == PH_IDLE && kind && op <= OP_POWER_UP) begin
            pend_op_next  = op;
            out_byte_next = write_byte;
            wait_cnt_next = '0;
            if (op <= OP_WRITE_CFG) begin
                phase_next = PH_WAIT;
            end else begin
                phase_next  = PH_HOLD;
                clk_st_next = (op == OP_POWER_DOWN);
            end
        end

        clk_o      = clk_st_next;
        half_inc   = half_cnt_next + 8'd1;
        idx_inc    = clk_idx_next + 6'd1;
        frame_len  = (pend_op_next == OP_READ_SAMPLE) ? SampleFrame : ConfigFrame;
        hold_limit = (pend_op_next == OP_POWER_DOWN) ? cfg.power_down_ticks
                                                     : cfg.power_up_ticks;

        case (phase_next)
            PH_WAIT: begin
                busy_o = 1'b1;
                if (!dio_level) begin
                    phase_next    = PH_HIGH;
                    half_cnt_next = '0;
                    clk_idx_next  = '0;
                    shift_next    = '0;
                end else if (wait_cnt_next >= cfg.wait_ticks) begin
                    phase_next  = PH_IDLE;
                    busy_o      = 1'b0;
                    done_o      = 1'b1;
                    status_next = 1'b1;
                end else begin
                    wait_cnt_next = wait_cnt_next + 20'd1;
                end
            end
            PH_HOLD: begin
                busy_o = 1'b1;
                if (wait_cnt_next >= hold_limit) begin
                    phase_next  = PH_IDLE;
                    busy_o      = 1'b0;
                    done_o      = 1'b1;
                    status_next = 1'b0;
                    pdown_next  = (pend_op_next == OP_POWER_DOWN);
                end else begin
                    wait_cnt_next = wait_cnt_next + 20'd1;
                end
            end
            PH_HIGH: begin
                clk_o  = 1'b1;
                busy_o = 1'b1;
                en_drv = clock_pins(pend_op_next, clk_idx_next, out_byte_next);
                half_cnt_next = half_inc;
                if (half_inc >= hp) begin
                    phase_next    = PH_LOW;
                    half_cnt_next = '0;
                end
            end
            PH_LOW: begin
                clk_o       = 1'b0;
                clk_st_next = 1'b0;
                busy_o      = 1'b1;
                en_drv      = clock_pins(pend_op_next, clk_idx_next, out_byte_next);
                half_cnt_next = half_inc;
                if (half_inc >= hp) begin
                    if (reads_bit(pend_op_next, clk_idx_next))
                        shift_next = {shift_reg[22:0], dio_level};
                    clk_idx_next  = idx_inc;
                    half_cnt_next = '0;
                    phase_next    = PH_HIGH;
                    if (idx_inc >= frame_len) begin
                        phase_next  = PH_IDLE;
                        busy_o      = 1'b0;
                        done_o      = 1'b1;
                        status_next = 1'b0;
                        pdown_next  = 1'b0;
                        if (pend_op_next == OP_READ_SAMPLE)
                            sample_next = shift_next;
                        else if (pend_op_next == OP_READ_CFG)
                            cfgbyte_next = shift_next[7:0];
                    end
                end
            end
            default: ;
        endcase

        res.clk_level   = clk_o;
        res.dio_drive   = en_drv[1] & en_drv[0];
        res.dio_enable  = en_drv[1];
        res.busy        = busy_o;
        res.done        = done_o;
        res.status      = status_next;
        res.sample      = sample_next;
        res.config_byte = cfgbyte_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            half_cnt_reg <= '0;
            clk_idx_reg  <= '0;
            shift_reg    <= '0;
            wait_cnt_reg <= '0;
            pdown_reg    <= 1'b0;
            pend_op_reg  <= '0;
            out_byte_reg <= '0;
            clk_st_reg   <= 1'b0;
            sample_reg   <= '0;
            cfgbyte_reg  <= '0;
            status_reg   <= 1'b0;
        end else if (step) begin
            phase_reg    <= phase_next;
            half_cnt_reg <= half_cnt_next;
            clk_idx_reg  <= clk_idx_next;
            shift_reg    <= shift_next;
            wait_cnt_reg <= wait_cnt_next;
            pdown_reg    <= pdown_next;
            pend_op_reg  <= pend_op_next;
            out_byte_reg <= out_byte_next;
            clk_st_reg   <= clk_st_next;
            sample_reg   <= sample_next;
            cfgbyte_reg  <= cfgbyte_next;
            status_reg   <= status_next;
        end
    end

    // frames only run for the three read/write requests
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HIGH || phase_reg == PH_LOW) |-> pend_op_reg <= OP_WRITE_CFG)
        else $error("frame running with a power request pending");

    // half-period counter never reaches the programmed length while clocking
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HIGH || phase_reg == PH_LOW) |-> half_cnt_reg < hp)
        else $error("half-period counter overran");

    // a power-down hold always drives clk high
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_HOLD && pend_op_reg == OP_POWER_DOWN) |-> clk_st_reg)
        else $error("power-down hold with clk low");

endmodule

// ===== hdl/two_wire_adc_interface_master_core.sv =====
// top level of the two-wire adc interface master: stream channels, apb port,
// result register; depends on twm_pkg, twm_cfg_regs and twm_sequencer
//
// usage:
//   each input transfer is one base time tick. s_tuser (kind) set means the
//   transfer also carries a request (op, write_byte); dio_level is the dio pin
//   sampled for that tick. for every input transfer exactly one result transfer
//   comes out, holding the pin levels to drive for that tick (clk_level,
//   dio_drive, dio_enable), busy/done flags, and the held status, sample and
//   config byte.
//   the result of an input transfer is in the output register in the next cycle.
//   throughput: one tick per cycle; the sequencer state is updated by a single
//   combinational pass per tick, so the rate is set only by the output register
//   draining.
//   stalls: when m_tready is low the result is held in the output register and
//   s_tready drops; with m_tready high the block takes a tick every cycle.
//   reset: aresetn low (synchronous) returns the sequencer to idle, clears held
//   results, loads the register defaults and empties the output register.
//   registers (apb, byte address 4*i): wait_ticks, half_period_ticks,
//   power_down_ticks, power_up_ticks; write only while no request runs.

module two_wire_adc_interface_master_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input ticks
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // [2:0] op, [10:3] write_byte, [11] dio_level, [15:12] zero
    input  logic [twm_pkg::InDataW-1:0]  s_tdata,
    // [0] kind
    input  logic                         s_tuser,
    // results
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] clk_level, [1] dio_drive, [2] dio_enable, [3] busy_res, [4] done_res,
    // [5] status, [29:6] sample, [37:30] config_byte, [39:38] zero
    output logic [twm_pkg::OutDataW-1:0] m_tdata,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [twm_pkg::RegAddrW-1:0] paddr,
    input  logic [twm_pkg::ApbDataW-1:0] pwdata,
    output logic [twm_pkg::ApbDataW-1:0] prdata,
    output logic                         pready
);
    import twm_pkg::*;

    cfg_t                cfg;
    result_t             res;
    logic                step;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OutDataW-1:0] m_tdata_reg,  m_tdata_next;

    // output register drains or is empty -> take the next tick
    assign s_tready = !m_tvalid_reg || m_tready;
    assign step     = s_tvalid && s_tready;

    twm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    twm_sequencer u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .kind       (s_tuser),
        .op         (s_tdata[2:0]),
        .write_byte (s_tdata[10:3]),
        .dio_level  (s_tdata[11]),
        .cfg        (cfg),
        .res        (res)
    );

    // result register: load on tick, clear valid once taken
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (step) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {2'b00, res.config_byte, res.sample, res.status, res.done,
                             res.busy, res.dio_enable, res.dio_drive, res.clk_level};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // every accepted tick yields a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("tick accepted without a result");

    // a finishing tick is never reported busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[4] && m_tdata[3]))
        else $error("done and busy together");

    // dio is only driven high while enabled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tdata[1] || m_tdata[2]))
        else $error("dio drive without enable");

endmodule
